// File: hw/rtl/lzm_pkg.sv
// ----------------------------------------------------------------------------
// lzm_pkg
// Shared types and constants for the layer z-order manager: field widths,
// request codes and the command word from the controller to the datapath.
// ----------------------------------------------------------------------------
package lzm_pkg;

	// field widths fixed by the request and result words
	localparam int LAYER_W = 5;
	localparam int COUNT_W = 4;

	// request codes
	localparam logic REQ_RAISE = 1'b0;
	localparam logic REQ_HIDE  = 1'b1;

	// pointer layer id, never moved
	localparam logic [LAYER_W-1:0] POINTER_LAYER = '0;

	// controller to datapath command word
	typedef struct packed {
		logic load;    // capture the request word
		logic walk;    // rotate the slot ring by one position
		logic first;   // current walk step is the first one
		logic finish;  // update the visible count and register the result word
	} cmd_t;

endpackage

// File: hw/rtl/lzm_ctrl.sv
// ----------------------------------------------------------------------------
// lzm_ctrl
// Sequencer of the layer z-order manager: accepts a request word, counts
// the ring walk steps and commands the datapath to load, walk and finish.
// ----------------------------------------------------------------------------
module lzm_ctrl #(
	parameter int SLOTS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        req_type,
	input  logic [lzm_pkg::LAYER_W-1:0] layer_id,
	output logic                        busy,
	output lzm_pkg::cmd_t               cmd
);

	localparam int SW = $clog2(SLOTS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FIN
	} state_t;

	state_t        state_q;
	logic [SW-1:0] step_q;
	logic          hide_q;
	logic          last_step;

	// a raise walks the ring once, a hide walks one extra step for its lag
	assign last_step = hide_q ? (step_q == SW'(SLOTS)) : (step_q == SW'(SLOTS - 1));

	assign busy = (state_q != ST_IDLE);

	// drive the command word from the state
	always_comb begin
		cmd.load   = (state_q == ST_IDLE) && start;
		cmd.walk   = (state_q == ST_WALK);
		cmd.first  = (state_q == ST_WALK) && (step_q == SW'(1));
		cmd.finish = (state_q == ST_FIN);
	end

	// hold state, step count and request kind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			hide_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						hide_q <= (req_type == lzm_pkg::REQ_HIDE);
						step_q <= SW'(1);
						// skip the walk for the pointer layer
						if (layer_id == lzm_pkg::POINTER_LAYER) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (last_step) begin
						state_q <= ST_FIN;
					end else begin
						step_q <= step_q + SW'(1);
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (step_q >= SW'(1) && step_q <= SW'(SLOTS)))
		else $error("walk step out of range");

	a_finish_frees: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !busy)
		else $error("controller still busy after finish");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !cmd.walk && !cmd.finish)
		else $error("load issued during walk or finish");

endmodule

// File: hw/rtl/lzm_dpath.sv
// ----------------------------------------------------------------------------
// lzm_dpath
// Datapath of the layer z-order manager: a ring of display slots that
// rotates one position per step, with a one-word delay register, so that a
// raise shifts entries back and a hide closes the gap while the ring turns.
// ----------------------------------------------------------------------------
module lzm_dpath #(
	parameter int SLOTS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lzm_pkg::cmd_t               cmd,
	input  logic                        req_type,
	input  logic [lzm_pkg::LAYER_W-1:0] layer_id,
	output logic                        done,
	output logic [lzm_pkg::LAYER_W-1:0] front_layer,
	output logic [lzm_pkg::COUNT_W-1:0] visible_count,
	output logic                        demoted_valid,
	output logic [lzm_pkg::LAYER_W-1:0] demoted_layer,
	output logic                        raised_valid,
	output logic                        dropped_valid,
	output logic [lzm_pkg::LAYER_W-1:0] dropped_layer
);

	localparam int N  = SLOTS - 1;        // slots 1 to SLOTS-1; slot 0 is fixed
	localparam int TW = $clog2(SLOTS);
	localparam int LW = lzm_pkg::LAYER_W;

	logic [LW-1:0] ring_q [N];
	logic [TW-1:0] top_q;
	logic [TW-1:0] rem_q;
	logic          req_q;
	logic [LW-1:0] id_q;
	logic          ign_q;
	logic [LW-1:0] d_q;
	logic          prev_in_q;
	logic          shift_q;
	logic          found_q;
	logic          gap_q;

	logic          done_q;
	logic [LW-1:0] front_q;
	logic [lzm_pkg::COUNT_W-1:0] count_q;
	logic          dem_v_q;
	logic [LW-1:0] dem_q;
	logic          rai_v_q;
	logic          drp_v_q;
	logic [LW-1:0] drp_q;

	logic [LW-1:0] x;
	logic          in_list;
	logic          hit;
	logic          gap_n;
	logic [LW-1:0] w;
	logic [TW-1:0] newtop;
	logic          drop;

	// step logic: x is the slot under the head of the ring
	always_comb begin
		x       = ring_q[0];
		in_list = (rem_q != '0);
		hit     = !cmd.first && prev_in_q && (d_q == id_q);
		gap_n   = gap_q | hit;
		if (req_q == lzm_pkg::REQ_RAISE) begin
			w = cmd.first ? id_q : (shift_q ? d_q : x);
		end else begin
			w = gap_n ? x : d_q;
		end
	end

	// new visible count and drop decision at finish
	always_comb begin
		newtop = top_q;
		drop   = 1'b0;
		if (!ign_q) begin
			if (req_q == lzm_pkg::REQ_RAISE) begin
				if (!found_q) begin
					if (top_q == TW'(N)) begin
						drop = 1'b1;
					end else begin
						newtop = top_q + TW'(1);
					end
				end
			end else if (gap_q) begin
				newtop = top_q - TW'(1);
			end
		end
	end

	// rotate the slot ring, write the transformed word at the tail
	always_ff @(posedge clk) begin
		if (cmd.walk) begin
			for (int k = 0; k < N - 1; k++) begin
				ring_q[k] <= ring_q[k+1];
			end
			ring_q[N-1] <= w;
		end
	end

	// capture the request word and advance the walk registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			id_q  <= layer_id;
			ign_q <= (layer_id == lzm_pkg::POINTER_LAYER);
		end
		if (cmd.load) begin
			rem_q     <= top_q;
			prev_in_q <= 1'b0;
			d_q       <= '0;
		end else if (cmd.walk) begin
			rem_q     <= rem_q - TW'(in_list);
			prev_in_q <= in_list;
			d_q       <= x;
		end
	end

	// hold the walk flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			found_q <= 1'b0;
			gap_q   <= 1'b0;
		end else if (cmd.load) begin
			shift_q <= 1'b1;
			found_q <= 1'b0;
			gap_q   <= 1'b0;
		end else if (cmd.walk) begin
			gap_q <= gap_n;
			if (in_list && (x == id_q)) begin
				found_q <= 1'b1;
				shift_q <= 1'b0;
			end
			if (!in_list) begin
				shift_q <= 1'b0;
			end
		end
	end

	// update the visible count and the strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.finish) begin
				top_q <= newtop;
			end
		end
	end

	// register the result word
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			front_q <= (newtop != '0) ? ring_q[0] : '0;
			count_q <= lzm_pkg::COUNT_W'(newtop);
			dem_v_q <= !ign_q && (newtop > TW'(2));
			dem_q   <= (!ign_q && (newtop > TW'(2))) ? ring_q[1] : '0;
			rai_v_q <= !ign_q && (newtop > TW'(1));
			drp_v_q <= drop;
			drp_q   <= drop ? d_q : '0;
		end
	end

	assign done          = done_q;
	assign front_layer   = front_q;
	assign visible_count = count_q;
	assign demoted_valid = dem_v_q;
	assign demoted_layer = dem_q;
	assign raised_valid  = rai_v_q;
	assign dropped_valid = drp_v_q;
	assign dropped_layer = drp_q;

	a_raise_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !ign_q && (req_q == lzm_pkg::REQ_RAISE)) |-> (top_q != '0))
		else $error("raise left no layer visible");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && drp_v_q) |-> (top_q == TW'(N)))
		else $error("drop reported while order not full");

	a_demote_raise: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && dem_v_q) |-> rai_v_q)
		else $error("demoted notice without raised notice");

endmodule

// File: hw/rtl/layer_zorder_manager.sv
// ----------------------------------------------------------------------------
// layer_zorder_manager
// Display stacking order of layer ids with move-to-front on raise and gap
// closing on hide; slot 0 stays with the pointer layer.
// Sequence: the accepting edge loads the request word, the ST_WALK state turns the
//   slot ring (skipped for the pointer layer), and ST_FIN registers the result word.
// A new word is taken only while busy is low, so one request is handled at a time;
//   results never stall.
// Reset: no layer visible, slot ring contents undefined until written.
// ----------------------------------------------------------------------------
module layer_zorder_manager #(
	parameter int SLOTS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        req_type,
	input  logic [lzm_pkg::LAYER_W-1:0] layer_id,
	output logic                        done,
	output logic [lzm_pkg::LAYER_W-1:0] front_layer,
	output logic [lzm_pkg::COUNT_W-1:0] visible_count,
	output logic                        demoted_valid,
	output logic [lzm_pkg::LAYER_W-1:0] demoted_layer,
	output logic                        raised_valid,
	output logic                        dropped_valid,
	output logic [lzm_pkg::LAYER_W-1:0] dropped_layer
);

	lzm_pkg::cmd_t cmd;

	// sequencer
	lzm_ctrl #(
		.SLOTS(SLOTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.layer_id (layer_id),
		.busy     (busy),
		.cmd      (cmd)
	);

	// slot ring and result registers
	lzm_dpath #(
		.SLOTS(SLOTS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.req_type      (req_type),
		.layer_id      (layer_id),
		.done          (done),
		.front_layer   (front_layer),
		.visible_count (visible_count),
		.demoted_valid (demoted_valid),
		.demoted_layer (demoted_layer),
		.raised_valid  (raised_valid),
		.dropped_valid (dropped_valid),
		.dropped_layer (dropped_layer)
	);

endmodule
